// File: src/utxd_pkg.sv
// ---------------------------------------------------------------------------
// utxd_pkg: shared types and constants for the UART transmit ring.
// Queue geometry, result codes and pointer helpers.
// ---------------------------------------------------------------------------
package utxd_pkg;

   localparam int QUEUE_DEPTH = 256;
   localparam int MAX_BURST   = 4;

   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int SENT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int BURST_W = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;
   localparam int FILL_W  = 8;
   localparam int EXT_W   = PTR_W + FILL_W + 1;

   typedef logic [PTR_W-1:0]   ptr_type;
   typedef logic [SENT_W-1:0]  sent_type;
   typedef logic [BURST_W-1:0] burst_type;

   typedef enum logic [1:0] {
      KIND_ACCEPTED = 2'd0,
      KIND_REJECTED = 2'd1,
      KIND_SENT     = 2'd2,
      KIND_NOTHING  = 2'd3
   } kind_type;

   localparam logic CMD_PUSH  = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   // pointer increment with wrap at the queue depth
   function automatic ptr_type ptr_adv(ptr_type p);
      ptr_type r;
      if (p == ptr_type'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + ptr_type'(1);
      end
      return r;
   endfunction

   // bytes queued, modulo depth, low 8 bits
   function automatic logic [FILL_W-1:0] fill_of(ptr_type w, ptr_type r);
      logic [EXT_W-1:0] d;
      if (w >= r) begin
         d = EXT_W'(w) - EXT_W'(r);
      end else begin
         d = EXT_W'(w) + EXT_W'(QUEUE_DEPTH) - EXT_W'(r);
      end
      return d[FILL_W-1:0];
   endfunction

endpackage

// File: src/utxd_if.sv
// ---------------------------------------------------------------------------
// utxd_if: valid/ready channels of the UART transmit ring.
// Request channel carries commands, response channel carries results.
// ---------------------------------------------------------------------------
interface utxd_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] data_byte;

   modport source (output valid, output cmd, output data_byte, input ready);
   modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface utxd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [7:0] tx_byte;
   logic       last;
   logic       queue_reset;
   logic       tx_request;
   logic [7:0] fill_level;

   modport source (output valid, output result_kind, output tx_byte, output last,
                   output queue_reset, output tx_request, output fill_level,
                   input ready);
   modport sink   (input valid, input result_kind, input tx_byte, input last,
                   input queue_reset, input tx_request, input fill_level,
                   output ready);
endinterface

// File: src/uart_tx_overwrite_ring_drain_unit.sv
// ---------------------------------------------------------------------------
// uart_tx_overwrite_ring_drain_unit: transmit byte ring for a serial port.
// Pushes queue nonzero bytes (oldest overwritten when full); drains send bursts.
// ---------------------------------------------------------------------------
// Usage:
//   req_ch carries one item per command: cmd=push stores data_byte, cmd=drain
//   asks for up to MAX_BURST queued bytes. rsp_ch returns the results, the
//   final one of each item flagged by last.
//   Push, zero-byte reject and empty drain: one result, loaded into the output
//   register at the accept edge (visible the next cycle).
//   Drain with data: the byte store is read at the accept edge, then one byte
//   per cycle while rsp_ch is ready, paced by the single read port of the
//   store and the read-pointer incrementer.
//   req_ch.ready is high only while the sequencer is idle and the output
//   register is free or being emptied; a stalled receiver holds the current
//   result and freezes the burst.
//   Reset clears pointers, sent counter, request flag and the sequencer. The
//   byte store is not cleared: only bytes between the pointers are ever read,
//   so no clearing pass is needed.
// ---------------------------------------------------------------------------
module uart_tx_overwrite_ring_drain_unit
   import utxd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   utxd_req_if.sink   req_ch,
   utxd_rsp_if.source rsp_ch
);

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type state_ff;

   // queue state
   ptr_type   wp_ff;
   ptr_type   rp_ff;
   sent_type  sent_ff;
   logic      flag_ff;
   burst_type burst_ff;

   // byte store, one write and one registered read port
   logic [7:0] mem [QUEUE_DEPTH];
   logic [7:0] rd_data_ff;

   // output register
   logic        rsp_valid_ff;
   kind_type    kind_ff;
   logic [7:0]  tx_byte_ff;
   logic        last_ff;
   logic        qreset_ff;
   logic        txreq_ff;
   logic [7:0]  fill_ff;

   logic     out_free;
   logic     req_ready;
   logic     acc;
   logic     is_push;
   logic     zero_byte;
   logic     empty;
   logic     rsp_load;
   ptr_type  rp_adv;
   ptr_type  wp_adv;
   ptr_type  rp_push;
   sent_type sent_in;
   logic     drain_end;
   logic     burst_last;
   logic     mem_we;
   logic     rd_en;
   ptr_type  rd_addr;

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign acc       = req_ch.valid && req_ready;
   assign is_push   = (req_ch.cmd == CMD_PUSH);
   assign zero_byte = (req_ch.data_byte == 8'd0);
   assign empty     = (wp_ff == rp_ff);

   // output register takes a new result this cycle
   assign rsp_load  = (state_ff == ST_EMIT) ? out_free : (acc && (is_push || empty));

   // shared pointer incrementers
   assign rp_adv  = ptr_adv(rp_ff);
   assign wp_adv  = ptr_adv(wp_ff);
   // full queue: writer catches reader, oldest byte dropped
   assign rp_push = (wp_adv == rp_ff) ? rp_adv : rp_ff;

   assign sent_in    = sent_ff + sent_type'(1);
   assign drain_end  = (sent_in == sent_type'(QUEUE_DEPTH)) || (wp_ff == rp_adv);
   assign burst_last = (burst_ff == burst_type'(MAX_BURST - 1));

   assign mem_we  = acc && is_push && !zero_byte;
   // first read at the accept edge, then prefetch the next byte per send
   assign rd_en   = (acc && !is_push && !empty) ||
                    ((state_ff == ST_EMIT) && out_free && !drain_end && !burst_last);
   assign rd_addr = (state_ff == ST_EMIT) ? rp_adv : rp_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wp_ff] <= req_ch.data_byte;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // sequencer, queue state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         sent_ff      <= '0;
         flag_ff      <= 1'b0;
         burst_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (acc) begin
                  tx_byte_ff <= 8'd0;
                  last_ff    <= 1'b1;
                  qreset_ff  <= 1'b0;
                  if (is_push) begin
                     flag_ff      <= 1'b1;
                     txreq_ff     <= 1'b1;
                     if (zero_byte) begin
                        kind_ff <= KIND_REJECTED;
                        fill_ff <= fill_of(wp_ff, rp_ff);
                     end else begin
                        kind_ff <= KIND_ACCEPTED;
                        wp_ff   <= wp_adv;
                        rp_ff   <= rp_push;
                        fill_ff <= fill_of(wp_adv, rp_push);
                     end
                  end else if (empty) begin
                     kind_ff      <= KIND_NOTHING;
                     txreq_ff     <= flag_ff;
                     fill_ff      <= fill_of(wp_ff, rp_ff);
                  end else begin
                     state_ff <= ST_EMIT;
                     burst_ff <= '0;
                  end
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  kind_ff      <= KIND_SENT;
                  tx_byte_ff   <= rd_data_ff;
                  burst_ff     <= burst_ff + burst_type'(1);
                  if (drain_end) begin
                     // emptied or counter wrapped: whole queue restarts
                     wp_ff     <= '0;
                     rp_ff     <= '0;
                     sent_ff   <= '0;
                     flag_ff   <= 1'b0;
                     last_ff   <= 1'b1;
                     qreset_ff <= 1'b1;
                     txreq_ff  <= 1'b0;
                     fill_ff   <= 8'd0;
                     state_ff  <= ST_IDLE;
                  end else begin
                     rp_ff     <= rp_adv;
                     sent_ff   <= sent_in;
                     last_ff   <= burst_last;
                     qreset_ff <= 1'b0;
                     txreq_ff  <= flag_ff;
                     fill_ff   <= fill_of(wp_ff, rp_adv);
                     if (burst_last) begin
                        state_ff <= ST_IDLE;
                     end
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ch.ready       = req_ready;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_kind = kind_ff;
   assign rsp_ch.tx_byte     = tx_byte_ff;
   assign rsp_ch.last        = last_ff;
   assign rsp_ch.queue_reset = qreset_ff;
   assign rsp_ch.tx_request  = txreq_ff;
   assign rsp_ch.fill_level  = fill_ff;

`ifndef SYNTH
   // a drain of a nonempty queue starts a burst
   a_drain_starts: assert property (@(posedge clock) disable iff (reset)
      (acc && !is_push && !empty) |=> (state_ff == ST_EMIT))
      else $error("drain did not start a burst");

   // only sent bytes carry data
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && kind_ff != KIND_SENT) |-> (tx_byte_ff == 8'd0))
      else $error("nonzero byte on a result that sends nothing");

   // queue restart ends the item with request cleared, fill zero and pointers equal
   a_qreset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && qreset_ff) |->
         (last_ff && !txreq_ff && fill_ff == 8'd0 && wp_ff == rp_ff))
      else $error("queue restart result inconsistent");
`endif

endmodule
